// ===== rtl/rtlf_pkg.sv =====
package rtlf_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);

  localparam int unsigned CW = 36;
  localparam logic signed [CW-1:0] HALF_PI_Q29 = 36'sd843314857;
  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032875;
  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
  localparam logic signed [63:0] D_MAX = 64'sd8589934591;

  typedef enum logic [2:0] {
    CFG_ROTATE_GAIN       = 3'd0,
    CFG_SPEED_GAIN        = 3'd1,
    CFG_LOOKAHEAD_WEIGHT  = 3'd2,
    CFG_SPEED_LIMIT       = 3'd3,
    CFG_TURN_RATE_LIMIT   = 3'd4,
    CFG_HEADING_TOLERANCE = 3'd5,
    CFG_ARRIVAL_RADIUS    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MS_RG_ERR, MS_AX2, MS_AY2, MS_SG_DIST, MS_EX_SH, MS_EY_CH, MS_LW_SD, MS_RG_D
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD8
  } acc_op_e;

  typedef enum logic [1:0] {
    COR_VEC, COR_ROT_H, COR_ROT_D
  } cor_mode_e;

  typedef struct packed {
    logic             load_in;
    logic             mul_en;
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    logic             cor_init;
    cor_mode_e        cor_mode;
    logic             cor_step;
    logic [CNT_W-1:0] iter;
    logic             head_we;
    logic             sq_init;
    logic             sq_step;
    logic             trig_h_we;
    logic             trig_d_we;
    logic             res_clr;
    logic             lin_we;
    logic             ang_we;
    logic             ang_line;
    logic             prev_we;
  } dp_cmd_t;

  typedef struct packed {
    logic aligned;
    logic arrived;
  } dp_stat_t;

  function automatic logic signed [CW-1:0] atan_q29(input logic [CNT_W-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      5'd0:    a = 36'sd421657428;
      5'd1:    a = 36'sd248918915;
      5'd2:    a = 36'sd131521918;
      5'd3:    a = 36'sd66762579;
      5'd4:    a = 36'sd33510843;
      5'd5:    a = 36'sd16771758;
      5'd6:    a = 36'sd8387925;
      5'd7:    a = 36'sd4194219;
      5'd8:    a = 36'sd2097141;
      5'd9:    a = 36'sd1048575;
      5'd10:   a = 36'sd524288;
      5'd11:   a = 36'sd262144;
      5'd12:   a = 36'sd131072;
      5'd13:   a = 36'sd65536;
      5'd14:   a = 36'sd32768;
      5'd15:   a = 36'sd16384;
      5'd16:   a = 36'sd8192;
      5'd17:   a = 36'sd4096;
      5'd18:   a = 36'sd2048;
      5'd19:   a = 36'sd1024;
      5'd20:   a = 36'sd512;
      5'd21:   a = 36'sd256;
      5'd22:   a = 36'sd128;
      5'd23:   a = 36'sd64;
      5'd24:   a = 36'sd32;
      5'd25:   a = 36'sd16;
      5'd26:   a = 36'sd8;
      5'd27:   a = 36'sd4;
      5'd28:   a = 36'sd2;
      5'd29:   a = 36'sd1;
      default: a = 36'sd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] sat_lim(input logic signed [67:0] v,
                                                 input logic [14:0] lim);
    logic signed [67:0] l;
    logic signed [15:0] r;
    l = $signed({53'b0, lim});
    if (v > l) begin
      r = $signed({1'b0, lim});
    end else if (v < -l) begin
      r = -$signed({1'b0, lim});
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rtlf_dp.sv =====
module rtlf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [143:0]       in_data_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [20:0]        cfg_data_i,
  input  rtlf_pkg::dp_cmd_t  cmd_i,
  output rtlf_pkg::dp_stat_t stat_o,
  output logic signed [15:0] lin_o,
  output logic signed [15:0] ang_o
);
  import rtlf_pkg::*;

  logic [15:0] rg_q, sg_q, lw_q;
  logic [14:0] slim_q, tlim_q, tol_q;
  logic [20:0] rad_q;

  logic signed [31:0] px_q, py_q, tx_q, ty_q;
  logic signed [15:0] yaw_q;
  logic signed [15:0] gh_q;
  logic signed [31:0] prevx_q, prevy_q;

  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic                 cvec_q;
  logic [63:0]          sqn_q, sqr_q, sqb_q;
  logic signed [67:0]   pq_q;
  logic signed [63:0]   acc_q;
  logic signed [16:0]   sh_q, ch_q, sd_q;
  logic signed [15:0]   lin_q, ang_q;

  logic signed [32:0] dx, dy, ex, ey, ax, ay;
  logic               big;
  logic [31:0]        axh, ayh;
  logic signed [16:0] err, aerr;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [63:0] dr;
  logic signed [33:0] dcl;
  logic [32:0]        gdist;
  logic signed [CW-1:0] xs, ys, at, ix, iy, iz, rz;
  logic               minus;
  logic signed [CW-1:0] hz;
  logic signed [15:0] head;
  logic [63:0]        sqt;
  logic signed [CW-1:0] sin_w, cos_w;

  function automatic logic tdx_zero();
    return (tx_q == px_q) && (ty_q == py_q);
  endfunction

  assign dx = {ty_q[31], ty_q} - {py_q[31], py_q};
  assign dy = dx;

  always_comb begin
    logic signed [32:0] tdx;
    logic signed [16:0] diff;
    tdx  = {tx_q[31], tx_q} - {px_q[31], px_q};
    ex   = {px_q[31], px_q} - {prevx_q[31], prevx_q};
    ey   = {py_q[31], py_q} - {prevy_q[31], prevy_q};
    ax   = tdx[32] ? -tdx : tdx;
    ay   = dy[32] ? -dy : dy;
    big  = ax[31] | ay[31];
    axh  = big ? {1'b0, ax[31:1]} : ax[31:0];
    ayh  = big ? {1'b0, ay[31:1]} : ay[31:0];
    diff = {gh_q[15], gh_q} - {yaw_q[15], yaw_q};
    if (diff > PI_Q13) begin
      diff = diff - TWO_PI_Q13;
    end
    if (diff < -PI_Q13) begin
      diff = diff + TWO_PI_Q13;
    end
    err  = diff;
    aerr = diff[16] ? -diff : diff;

    // Start vector for the shared CORDIC.
    ix = '0;
    iy = '0;
    iz = '0;
    rz = '0;
    if (cmd_i.cor_mode == COR_VEC) begin
      ix = CW'(tdx);
      iy = CW'(dy);
      if (tdx[32]) begin
        if (!dy[32]) begin
          ix = CW'(dy);
          iy = -CW'(tdx);
          iz = HALF_PI_Q29;
        end else begin
          ix = -CW'(dy);
          iy = CW'(tdx);
          iz = -HALF_PI_Q29;
        end
      end
    end else begin
      rz = (cmd_i.cor_mode == COR_ROT_H) ? (CW'(gh_q) <<< 16) : (CW'(err) <<< 16);
      ix = INV_GAIN_Q30;
      iz = rz;
      if (rz > HALF_PI_Q29) begin
        ix = '0;
        iy = INV_GAIN_Q30;
        iz = rz - HALF_PI_Q29;
      end else if (rz < -HALF_PI_Q29) begin
        ix = '0;
        iy = -INV_GAIN_Q30;
        iz = rz + HALF_PI_Q29;
      end
    end
  end

  assign xs    = cx_q >>> cmd_i.iter;
  assign ys    = cy_q >>> cmd_i.iter;
  assign at    = atan_q29(cmd_i.iter);
  assign minus = cvec_q ? cy_q[CW-1] : !cz_q[CW-1];

  assign hz = (cz_q + CW'(32768)) >>> 16;
  always_comb begin
    if ((tdx_zero()) ) begin
      head = '0;
    end else if (hz > CW'(PI_Q13)) begin
      head = 16'(PI_Q13);
    end else if (hz < -CW'(PI_Q13)) begin
      head = -16'(PI_Q13);
    end else begin
      head = hz[15:0];
    end
  end

  assign sin_w = (cy_q + CW'(16384)) >>> 15;
  assign cos_w = (cx_q + CW'(16384)) >>> 15;

  assign sqt   = sqr_q + sqb_q;
  assign gdist = big ? {sqr_q[31:0], 1'b0} : {1'b0, sqr_q[31:0]};

  assign dr  = (acc_q + 64'sd16384) >>> 15;
  assign dcl = (dr > D_MAX) ? D_MAX[33:0] : ((dr < -D_MAX) ? -D_MAX[33:0] : dr[33:0]);

  always_comb begin
    case (cmd_i.mul_sel)
      MS_RG_ERR: begin
        ma = {{17{err[16]}}, err};
        mb = $signed({18'b0, rg_q});
      end
      MS_AX2: begin
        ma = $signed({2'b0, axh});
        mb = $signed({2'b0, axh});
      end
      MS_AY2: begin
        ma = $signed({2'b0, ayh});
        mb = $signed({2'b0, ayh});
      end
      MS_SG_DIST: begin
        ma = $signed({1'b0, gdist});
        mb = $signed({18'b0, sg_q});
      end
      MS_EX_SH: begin
        ma = {ex[32], ex};
        mb = {{17{sh_q[16]}}, sh_q};
      end
      MS_EY_CH: begin
        ma = {ey[32], ey};
        mb = {{17{ch_q[16]}}, ch_q};
      end
      MS_LW_SD: begin
        ma = {{17{sd_q[16]}}, sd_q};
        mb = $signed({18'b0, lw_q});
      end
      MS_RG_D: begin
        ma = dcl;
        mb = $signed({18'b0, rg_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rg_q    <= 16'd26;
      sg_q    <= 16'd26;
      lw_q    <= 16'd256;
      slim_q  <= 15'd2048;
      tlim_q  <= 15'd4096;
      tol_q   <= 15'd819;
      rad_q   <= 21'd6554;
      gh_q    <= '0;
      prevx_q <= '0;
      prevy_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROTATE_GAIN:       rg_q   <= cfg_data_i[15:0];
          CFG_SPEED_GAIN:        sg_q   <= cfg_data_i[15:0];
          CFG_LOOKAHEAD_WEIGHT:  lw_q   <= cfg_data_i[15:0];
          CFG_SPEED_LIMIT:       slim_q <= cfg_data_i[14:0];
          CFG_TURN_RATE_LIMIT:   tlim_q <= cfg_data_i[14:0];
          CFG_HEADING_TOLERANCE: tol_q  <= cfg_data_i[14:0];
          CFG_ARRIVAL_RADIUS:    rad_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.head_we) begin
        gh_q <= head;
      end
      if (cmd_i.prev_we) begin
        prevx_q <= px_q;
        prevy_q <= py_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q  <= in_data_i[31:0];
      py_q  <= in_data_i[63:32];
      yaw_q <= in_data_i[79:64];
      tx_q  <= in_data_i[111:80];
      ty_q  <= in_data_i[143:112];
    end
    if (cmd_i.cor_init) begin
      cx_q   <= ix;
      cy_q   <= iy;
      cz_q   <= iz;
      cvec_q <= (cmd_i.cor_mode == COR_VEC);
    end else if (cmd_i.cor_step) begin
      if (minus) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.sq_init) begin
      sqn_q <= acc_q;
      sqr_q <= '0;
      sqb_q <= 64'd1 << 62;
    end else if (cmd_i.sq_step) begin
      if (sqn_q >= sqt) begin
        sqn_q <= sqn_q - sqt;
        sqr_q <= (sqr_q >> 1) + sqb_q;
      end else begin
        sqr_q <= sqr_q >> 1;
      end
      sqb_q <= sqb_q >> 2;
    end
    if (cmd_i.mul_en) begin
      pq_q <= prod;
    end
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= pq_q[63:0];
      ACC_ADD:  acc_q <= acc_q + pq_q[63:0];
      ACC_SUB:  acc_q <= acc_q - pq_q[63:0];
      ACC_ADD8: acc_q <= acc_q + (pq_q[63:0] <<< 8);
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.trig_h_we) begin
      sh_q <= sin_w[16:0];
      ch_q <= cos_w[16:0];
    end
    if (cmd_i.trig_d_we) begin
      sd_q <= sin_w[16:0];
    end
    if (cmd_i.res_clr) begin
      lin_q <= '0;
      ang_q <= '0;
    end else begin
      if (cmd_i.lin_we) begin
        lin_q <= sat_lim((pq_q + 68'sd2048) >>> 12, slim_q);
      end
      if (cmd_i.ang_we) begin
        if (cmd_i.ang_line) begin
          ang_q <= sat_lim((pq_q + 68'sd2048) >>> 12, tlim_q);
        end else begin
          ang_q <= sat_lim((pq_q + 68'sd256) >>> 9, tlim_q);
        end
      end
    end
  end

  assign stat_o.aligned = (aerr <= $signed({2'b0, tol_q}));
  assign stat_o.arrived = (gdist <= {12'b0, rad_q});
  assign lin_o = lin_q;
  assign ang_o = ang_q;

endmodule

// ===== rtl/rtlf_ctrl.sv =====
module rtlf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output logic               emit_o,
  output logic [1:0]         phase_o,
  output logic               reached_o,
  output rtlf_pkg::dp_cmd_t  cmd_o,
  input  rtlf_pkg::dp_stat_t stat_i
);
  import rtlf_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_DECIDE   = 22'h000002,
    S_VEC      = 22'h000004,
    S_HEAD     = 22'h000008,
    S_ROT_CHK  = 22'h000010,
    S_ROT_ANG  = 22'h000020,
    S_SQ_AY    = 22'h000040,
    S_SQ_SUM   = 22'h000080,
    S_SQ_INIT  = 22'h000100,
    S_SQRT     = 22'h000200,
    S_DIST     = 22'h000400,
    S_LIN      = 22'h000800,
    S_SC_H     = 22'h001000,
    S_SC_H_END = 22'h002000,
    S_SC_D     = 22'h004000,
    S_SC_D_END = 22'h008000,
    S_M2       = 22'h010000,
    S_M3       = 22'h020000,
    S_M4       = 22'h040000,
    S_M5       = 22'h080000,
    S_M6       = 22'h100000,
    S_DONE     = 22'h200000
  } state_e;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_ROT  = 2'd1;
  localparam logic [1:0] PH_LINE = 2'd2;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       phase_q, phase_d;
  logic             reached_q, reached_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    reached_d  = reached_q;
    cmd_o      = '0;
    cmd_o.iter = cnt_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        reached_d = 1'b0;
        if (phase_q == PH_ROT) begin
          state_d = S_ROT_CHK;
        end else if (phase_q == PH_LINE) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MS_AX2;
          state_d       = S_SQ_AY;
        end else begin
          cmd_o.cor_init = 1'b1;
          cmd_o.cor_mode = COR_VEC;
          cnt_d          = '0;
          state_d        = S_VEC;
        end
      end
      S_VEC: begin
        cmd_o.cor_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CORDIC_LAST) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o.head_we = 1'b1;
        phase_d       = PH_ROT;
        state_d       = S_ROT_CHK;
      end
      S_ROT_CHK: begin
        cmd_o.res_clr = 1'b1;
        if (stat_i.aligned) begin
          phase_d = PH_LINE;
          state_d = S_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MS_RG_ERR;
          state_d       = S_ROT_ANG;
        end
      end
      S_ROT_ANG: begin
        cmd_o.ang_we = 1'b1;
        state_d      = S_DONE;
      end
      S_SQ_AY: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_AY2;
        state_d       = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_SQ_INIT;
      end
      S_SQ_INIT: begin
        cmd_o.sq_init = 1'b1;
        cnt_d         = '0;
        state_d       = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          state_d = S_DIST;
        end
      end
      S_DIST: begin
        if (stat_i.arrived) begin
          cmd_o.res_clr = 1'b1;
          cmd_o.prev_we = 1'b1;
          reached_d     = 1'b1;
          phase_d       = PH_WAIT;
          state_d       = S_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MS_SG_DIST;
          state_d       = S_LIN;
        end
      end
      S_LIN: begin
        cmd_o.lin_we   = 1'b1;
        cmd_o.cor_init = 1'b1;
        cmd_o.cor_mode = COR_ROT_H;
        cnt_d          = '0;
        state_d        = S_SC_H;
      end
      S_SC_H: begin
        cmd_o.cor_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CORDIC_LAST) begin
          state_d = S_SC_H_END;
        end
      end
      S_SC_H_END: begin
        cmd_o.trig_h_we = 1'b1;
        cmd_o.cor_init  = 1'b1;
        cmd_o.cor_mode  = COR_ROT_D;
        cnt_d           = '0;
        state_d         = S_SC_D;
      end
      S_SC_D: begin
        cmd_o.cor_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CORDIC_LAST) begin
          state_d = S_SC_D_END;
        end
      end
      S_SC_D_END: begin
        cmd_o.trig_d_we = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MS_EX_SH;
        state_d         = S_M2;
      end
      S_M2: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_EY_CH;
        state_d       = S_M3;
      end
      S_M3: begin
        cmd_o.acc_op  = ACC_SUB;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_LW_SD;
        state_d       = S_M4;
      end
      S_M4: begin
        cmd_o.acc_op = ACC_ADD8;
        state_d      = S_M5;
      end
      S_M5: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_RG_D;
        state_d       = S_M6;
      end
      S_M6: begin
        cmd_o.ang_we   = 1'b1;
        cmd_o.ang_line = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      phase_q   <= PH_WAIT;
      reached_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      reached_q <= reached_d;
    end
  end

  assign phase_o   = phase_q;
  assign reached_o = reached_q;

endmodule

// ===== rtl/rotate_then_line_follow_controller.sv =====
// Go-to-goal controller that first turns toward the goal and then follows the
// line to it. Each item on the slave stream is one pose sample with the
// current goal; each item on the master stream is one velocity command.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while no sample is in flight,
// which the block does not enforce; a write takes effect at once. A sample
// is taken only while the block is idle. The first sample of a goal runs the
// 16-step CORDIC heading; the line phase runs the 32-step square root and
// two 16-step CORDIC sine passes, all on one shared CORDIC unit and one
// multiplier. The result then sits in an output register; the next sample
// is accepted and computed while it waits, and a finished second result waits
// in the core until the receiver takes the first. Reset clears the phase to
// awaiting a goal start, the heading and the previous goal to zero, loads the
// registers with their default values and empties the output register.
module rotate_then_line_follow_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x, pos_y, yaw, target_x, target_y
  input  logic [143:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // linear_cmd, angular_cmd, phase_now, goal_reached, zero fill
  output logic [39:0]  m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [20:0]  cfg_data_i
);
  import rtlf_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               out_free, emit, reached;
  logic [1:0]         phase;
  logic signed [15:0] lin, ang;
  logic               out_valid_q;
  logic [39:0]        out_data_q;

  rtlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .emit_o     (emit),
    .phase_o    (phase),
    .reached_o  (reached),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  rtlf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .lin_o      (lin),
    .ang_o      (ang)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {5'b0, reached, phase, ang, lin};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== dv/rtlf_scoreboard.sv =====
`timescale 1ns / 100ps

module rtlf_scoreboard (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [143:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [39:0]  m_data_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [20:0]  cfg_data_i,
  output int           errors_o,
  output int           pending_o
);
  import rtlf_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ROTATE = 2'd1;
  localparam logic [1:0] PH_LINE = 2'd2;
  localparam longint PI_A = 25736;
  localparam longint TWO_PI_A = 51472;
  localparam longint HALF_PI_A = 843314857;
  localparam longint INV_GAIN_A = 652032875;
  localparam longint ANGLE_TAB [32] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4,
    2, 1, 0, 0};

  typedef struct packed {
    logic [15:0] lin;
    logic [15:0] ang;
    logic [1:0]  phase;
    logic        reached;
  } cmd_t;

  cmd_t cmd_q [$];
  longint rot_gain, spd_gain, look_w, spd_lim, turn_lim, head_tol, arr_rad;
  logic [1:0] ph;
  longint heading, last_gx, last_gy;

  assign pending_o = cmd_q.size();

  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clampv(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic longint wrapa(longint a);
    if (a > PI_A) a -= TWO_PI_A;
    if (a < -PI_A) a += TWO_PI_A;
    return a;
  endfunction

  function automatic longint heading_to(longint y0, longint x0);
    longint x, y, z, t, xs, ys;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_A;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_A;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys; y = y + xs; z -= ANGLE_TAB[i];
      end else begin
        x = x + ys; y = y - xs; z += ANGLE_TAB[i];
      end
    end
    return clampv(rnd(z, 16), PI_A);
  endfunction

  task automatic sin_cos(input longint a, output longint s, output longint c);
    longint z, x, y, xs, ys;
    z = a * 65536;
    x = INV_GAIN_A;
    y = 0;
    if (z > HALF_PI_A) begin
      x = 0; y = INV_GAIN_A; z -= HALF_PI_A;
    end else if (z < -HALF_PI_A) begin
      x = 0; y = -INV_GAIN_A; z += HALF_PI_A;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= ANGLE_TAB[i];
      end else begin
        x = x + ys; y = y - xs; z += ANGLE_TAB[i];
      end
    end
    s = rnd(y, 15);
    c = rnd(x, 15);
  endtask

  function automatic longint unsigned root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint range_to(longint dx, longint dy);
    longint unsigned ax, ay;
    int sh;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sh = 0;
    if (ax >= 64'd2147483648 || ay >= 64'd2147483648) begin
      ax >>= 1; ay >>= 1; sh = 1;
    end
    return longint'(root(ax * ax + ay * ay) << sh);
  endfunction

  task automatic predict_cmd(input logic [143:0] d);
    longint px, py, yaw, tx, ty, lin, ang, err, aerr, gdist, sh, ch, sd, cd, sum, dd;
    cmd_t r;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    yaw = longint'($signed(d[79:64]));
    tx = longint'($signed(d[111:80]));
    ty = longint'($signed(d[143:112]));
    lin = 0;
    ang = 0;
    r.reached = 1'b0;
    if (ph != PH_ROTATE && ph != PH_LINE) begin
      heading = heading_to(ty - py, tx - px);
      ph = PH_ROTATE;
    end
    if (ph == PH_ROTATE) begin
      err = wrapa(heading - yaw);
      aerr = err < 0 ? -err : err;
      if (aerr <= head_tol) ph = PH_LINE;
      else ang = clampv(rnd(rot_gain * err, 9), turn_lim);
    end else begin
      gdist = range_to(tx - px, ty - py);
      if (gdist > arr_rad) begin
        lin = clampv(rnd(spd_gain * gdist, 12), spd_lim);
        sin_cos(heading, sh, ch);
        sin_cos(wrapa(heading - yaw), sd, cd);
        sum = (px - last_gx) * sh - (py - last_gy) * ch + look_w * sd * 256;
        dd = rnd(sum, 15);
        ang = clampv(rnd(rot_gain * dd, 12), turn_lim);
      end else begin
        r.reached = 1'b1;
        last_gx = px;
        last_gy = py;
        ph = PH_IDLE;
      end
    end
    r.lin = lin[15:0];
    r.ang = ang[15:0];
    r.phase = ph;
    cmd_q.insert(cmd_q.size(), r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t e;
    if (!rst_ni) begin
      rot_gain = 26; spd_gain = 26; look_w = 256; spd_lim = 2048;
      turn_lim = 4096; head_tol = 819; arr_rad = 6554;
      ph = PH_IDLE; heading = 0; last_gx = 0; last_gy = 0;
      cmd_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROTATE_GAIN:       rot_gain = cfg_data_i[15:0];
          CFG_SPEED_GAIN:        spd_gain = cfg_data_i[15:0];
          CFG_LOOKAHEAD_WEIGHT:  look_w = cfg_data_i[15:0];
          CFG_SPEED_LIMIT:       spd_lim = cfg_data_i[14:0];
          CFG_TURN_RATE_LIMIT:   turn_lim = cfg_data_i[14:0];
          CFG_HEADING_TOLERANCE: head_tol = cfg_data_i[14:0];
          CFG_ARRIVAL_RADIUS:    arr_rad = cfg_data_i[20:0];
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, m_data_i);
          errors_o++;
        end else begin
          e = cmd_q.pop_front();
          if (m_data_i[15:0] !== e.lin) begin
            $display("%0t: linear_cmd exp %0d act %0d", $time, $signed(e.lin),
                     $signed(m_data_i[15:0]));
            errors_o++;
          end
          if (m_data_i[31:16] !== e.ang) begin
            $display("%0t: angular_cmd exp %0d act %0d", $time, $signed(e.ang),
                     $signed(m_data_i[31:16]));
            errors_o++;
          end
          if (m_data_i[33:32] !== e.phase) begin
            $display("%0t: phase_now exp %0d act %0d", $time, e.phase,
                     m_data_i[33:32]);
            errors_o++;
          end
          if (m_data_i[34] !== e.reached) begin
            $display("%0t: goal_reached exp %0d act %0d", $time, e.reached,
                     m_data_i[34]);
            errors_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) predict_cmd(s_data_i);
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rtlf_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [143:0] s_data = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [39:0]  m_data;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_idx = '0;
  logic [20:0]  cfg_data = '0;
  int           errors;
  int           pending;
  int           snd_idle = 0;
  int           rcv_idle = 0;
  bit           hold_rx = 1'b0;

  rotate_then_line_follow_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  rtlf_scoreboard u_sb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_i   (s_data),
    .m_valid_i  (m_valid),
    .m_ready_i  (m_ready),
    .m_data_i   (m_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rx && !held) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      m_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send(input longint px, input longint py, input longint yaw,
                      input longint tx, input longint ty);
    logic [31:0] a, b, c, e;
    logic [15:0] w;
    a = px[31:0]; b = py[31:0]; w = yaw[15:0]; c = tx[31:0]; e = ty[31:0];
    while ($urandom_range(0, 99) < snd_idle) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {e, c, w, b, a};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[20:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic longint rand_pos();
    if ($urandom_range(0, 9) < 3) return longint'($signed($urandom()));
    return longint'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  function automatic longint rand_yaw();
    return longint'($urandom_range(0, 51472)) - 25736;
  endfunction

  function automatic longint aim(longint dx, longint dy);
    longint a;
    a = longint'($atan2(real'(dy), real'(dx)) * 8192.0);
    a += longint'($urandom_range(0, 40)) - 20;
    if (a > 25736) a = 25736;
    if (a < -25736) a = -25736;
    return a;
  endfunction

  task automatic run_goal();
    longint px, py, tx, ty, hd, cx, cy;
    int n;
    px = rand_pos();
    py = rand_pos();
    if ($urandom_range(0, 9) < 8) begin
      tx = px + longint'($urandom_range(0, 1048576)) - 524288;
      ty = py + longint'($urandom_range(0, 1048576)) - 524288;
    end else begin
      tx = rand_pos();
      ty = rand_pos();
    end
    tx = longint'($signed(tx[31:0]));
    ty = longint'($signed(ty[31:0]));
    hd = aim(tx - px, ty - py);
    repeat ($urandom_range(0, 2)) send(px, py, rand_yaw(), tx, ty);
    send(px, py, hd, tx, ty);
    n = $urandom_range(1, 8);
    for (int k = 1; k < n; k++) begin
      cx = px + (tx - px) * k / n + longint'($urandom_range(0, 4000)) - 2000;
      cy = py + (ty - py) * k / n + longint'($urandom_range(0, 4000)) - 2000;
      send(cx, cy, hd + longint'($urandom_range(0, 2000)) - 1000, tx, ty);
    end
    send(tx, ty, rand_yaw(), tx, ty);
  endtask

  task automatic load_setting(input int sel);
    int unsigned v [7];
    case (sel)
      0: v = '{26, 26, 256, 2048, 4096, 819, 6554};
      1: v = '{65535, 65535, 65535, 32767, 32767, 25736, 1048576};
      2: v = '{0, 0, 0, 0, 0, 0, 0};
      3: v = '{300, 4000, 1024, 8000, 8000, 200, 30000};
      default: v = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom_range(0, 25736),
                     $urandom_range(0, 1048576)};
    endcase
    write_reg(CFG_ROTATE_GAIN, v[0]);
    write_reg(CFG_SPEED_GAIN, v[1]);
    write_reg(CFG_LOOKAHEAD_WEIGHT, v[2]);
    write_reg(CFG_SPEED_LIMIT, v[3]);
    write_reg(CFG_TURN_RATE_LIMIT, v[4]);
    write_reg(CFG_HEADING_TOLERANCE, v[5]);
    write_reg(CFG_ARRIVAL_RADIUS, v[6]);
  endtask

  initial begin
    int sent;
    bit paused;
    paused = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(0, 0, 0, 0, 0);
    send(0, 0, 0, 0, 0);
    send(-2147483648, -2147483648, 25736, 2147483647, 2147483647);
    send(-2147483648, -2147483648, -25736, 2147483647, 2147483647);
    send(2147483647, -2147483648, 25736, -2147483648, 2147483647);
    send(2147483647, 2147483647, -25736, -2147483648, -2147483648);
    send(-2147483648, 2147483647, 25736, 2147483647, -2147483648);
    send(-2147483648, 2147483647, 0, -2147483648, 2147483647);
    send(100000, 0, 25736, 0, 0);
    send(100000, 0, 25736, 0, 0);
    send(50000, 3000, 25736, 0, 0);
    send(0, 0, 25000, 0, 0);
    send(0, 0, 0, 0, 65536);
    send(0, 0, -25736, 0, 65536);
    send(0, 0, 12868, 0, 65536);
    send(0, 30000, 12000, 0, 65536);
    send(0, 65536, 0, 0, 65536);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        snd_idle = 15; rcv_idle = 45;
      end else if (p < 4) begin
        snd_idle = 45; rcv_idle = 15;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      load_setting(p);
      sent = 0;
      while (sent < 290) begin
        if (p == 0 && sent >= 100) hold_rx = 1'b1;
        if (p == 1 && sent >= 150 && !paused) begin
          paused = 1'b1;
          s_valid <= 1'b0;
          @(negedge clk_i);
          while (pending != 0) @(negedge clk_i);
        end
        if ($urandom_range(0, 9) == 0) begin
          send(rand_pos(), rand_pos(), rand_yaw(), rand_pos(), rand_pos());
          sent++;
        end else begin
          run_goal();
          sent += 6;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
